// File: rtl/multi_stack_engine_unit_macros.svh
// Assertion helpers for the stack engine checker.
// Expect signals named clk and arst_n in the scope of each use.
`ifndef MULTI_STACK_ENGINE_UNIT_MACROS_SVH
`define MULTI_STACK_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication.
`define MSE_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MSE_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/mse_pkg.sv
package mse_pkg;

	localparam int WORD_W      = 32;
	localparam int MODE_W      = 2;
	localparam int STACK_W     = 3;
	localparam int STACK_SLOTS = 8;
	localparam int FILL_W      = 8;
	localparam int NSTK_W      = 4;
	localparam int DEPTH_W     = 8;
	localparam int BASE_W      = STACK_W + DEPTH_W;
	localparam int SUM_W       = BASE_W + 1;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 8;

	localparam logic [CFG_IDX_W-1:0] CFG_STACKS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_DEPTH  = 1'b1;

	localparam logic [NSTK_W-1:0]  STACKS_RESET = 4'd8;
	localparam logic [DEPTH_W-1:0] DEPTH_RESET  = 8'd128;

	typedef enum logic [MODE_W-1:0] {
		MODE_PUSH = 2'd0,
		MODE_POP  = 2'd1,
		MODE_PEEK = 2'd2,
		MODE_CMP  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_FULL    = 2'd2,
		ST_EMPTY   = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EXEC,
		S_PEEK,
		S_FILL_B,
		S_CMP_START,
		S_CMP_RD,
		S_CMP_CHK
	} state_t;

	typedef struct packed {
		logic    take;
		logic    fill_sel_b;
		logic    load_fb;
		logic    fill_inc;
		logic    fill_dec;
		logic    store_wr;
		logic    rd_peek;
		logic    rd_cmp;
		logic    idx_clr;
		logic    idx_inc;
		logic    load_out;
		status_t out_status;
		logic    out_top;
		logic    out_eq;
	} cmd_t;

	typedef struct packed {
		mode_t mode;
		logic  invalid;
		logic  full;
		logic  empty;
		logic  counts_eq;
		logic  last;
		logic  words_eq;
	} stat_t;

endpackage

// File: rtl/mse_in_if.sv
interface mse_in_if;
	logic                                valid;
	logic                                ready;
	logic [mse_pkg::MODE_W-1:0]          mode;
	logic [mse_pkg::STACK_W-1:0]         stack_a;
	logic [mse_pkg::STACK_W-1:0]         stack_b;
	logic signed [mse_pkg::WORD_W-1:0]   push_value;

	modport source (output valid, mode, stack_a, stack_b, push_value, input ready);
	modport sink   (input valid, mode, stack_a, stack_b, push_value, output ready);
endinterface

// File: rtl/mse_out_if.sv
interface mse_out_if;
	logic                                valid;
	logic                                ready;
	logic [1:0]                          status;
	logic signed [mse_pkg::WORD_W-1:0]   top_value;
	logic                                stacks_equal;

	modport source (output valid, status, top_value, stacks_equal, input ready);
	modport sink   (input valid, status, top_value, stacks_equal, output ready);
endinterface

// File: rtl/multi_stack_engine_unit.sv
// Channel   Dir  Fields                                    Handshake
// op_ch     in   mode, stack_a, stack_b, push_value        valid/ready
// res_ch    out  status, top_value, stacks_equal           valid/ready
// cfg       in   cfg_index, cfg_wdata                      cfg_we, no stall
//
// One item at a time. Push and pop end in the execute state; peek adds one store read.
// Compare reads stack B's fill, then ends if a stack is invalid or the counts differ
// or are zero, else reads up to count word pairs; it stops at the first mismatch.
// Reset clears control state and fill counts and sets 8 stacks of depth 128;
// the store is not cleared. A result waits in an output register; the engine
// takes the next item while it waits, but holds its own finish until the slot frees.
module multi_stack_engine_unit #(
	parameter int MAX_STACKS = 8,
	parameter int MAX_DEPTH  = 128
) (
	input  logic                            clk,
	input  logic                            arst_n,
	mse_in_if.sink                          op_ch,
	mse_out_if.source                       res_ch,
	input  logic                            cfg_we,
	input  logic [mse_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [mse_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	mse_pkg::cmd_t  cmd;
	mse_pkg::stat_t stat;
	mse_pkg::mode_t in_mode;

	assign in_mode = mse_pkg::mode_t'(op_ch.mode);

	// Sequencer: decides each step and when the result is loaded.
	mse_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (op_ch.valid),
		.in_mode   (in_mode),
		.in_ready  (op_ch.ready),
		.out_ready (res_ch.ready),
		.out_valid (res_ch.valid),
		.stat      (stat),
		.cmd       (cmd)
	);

	// Store, fill counts, config registers and the result register.
	mse_datapath #(
		.MAX_STACKS (MAX_STACKS),
		.MAX_DEPTH  (MAX_DEPTH)
	) u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.in_mode          (in_mode),
		.in_stack_a       (op_ch.stack_a),
		.in_stack_b       (op_ch.stack_b),
		.in_push_value    (op_ch.push_value),
		.cmd              (cmd),
		.stat             (stat),
		.out_status       (res_ch.status),
		.out_top_value    (res_ch.top_value),
		.out_stacks_equal (res_ch.stacks_equal)
	);

endmodule

// File: rtl/mse_ctrl.sv
module mse_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  mse_pkg::mode_t       in_mode,
	output logic                 in_ready,
	input  logic                 out_ready,
	output logic                 out_valid,
	input  mse_pkg::stat_t       stat,
	output mse_pkg::cmd_t        cmd
);

	mse_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            slot_free;

	assign slot_free = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mse_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			mse_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					state_d  = (in_mode == mse_pkg::MODE_CMP) ? mse_pkg::S_FILL_B
						: mse_pkg::S_EXEC;
				end
			end
			mse_pkg::S_EXEC: begin
				// Side effects fire only together with the result load.
				if (stat.invalid) begin
					cmd.load_out   = slot_free;
					cmd.out_status = mse_pkg::ST_INVALID;
				end else begin
					unique case (stat.mode)
						mse_pkg::MODE_PUSH: begin
							cmd.load_out = slot_free;
							if (stat.full) begin
								cmd.out_status = mse_pkg::ST_FULL;
							end else begin
								cmd.out_status = mse_pkg::ST_OK;
								cmd.store_wr   = slot_free;
								cmd.fill_inc   = slot_free;
							end
						end
						mse_pkg::MODE_POP: begin
							cmd.load_out = slot_free;
							if (stat.empty) begin
								cmd.out_status = mse_pkg::ST_EMPTY;
							end else begin
								cmd.out_status = mse_pkg::ST_OK;
								cmd.fill_dec   = slot_free;
							end
						end
						default: begin
							if (stat.empty) begin
								cmd.load_out   = slot_free;
								cmd.out_status = mse_pkg::ST_EMPTY;
							end else begin
								cmd.rd_peek = 1'b1;
							end
						end
					endcase
				end
				if (cmd.load_out) begin
					state_d = mse_pkg::S_IDLE;
				end else if (cmd.rd_peek) begin
					state_d = mse_pkg::S_PEEK;
				end
			end
			mse_pkg::S_PEEK: begin
				cmd.load_out   = slot_free;
				cmd.out_status = mse_pkg::ST_OK;
				cmd.out_top    = 1'b1;
				if (slot_free) begin
					state_d = mse_pkg::S_IDLE;
				end
			end
			mse_pkg::S_FILL_B: begin
				cmd.fill_sel_b = 1'b1;
				cmd.load_fb    = 1'b1;
				state_d        = mse_pkg::S_CMP_START;
			end
			mse_pkg::S_CMP_START: begin
				if (stat.invalid) begin
					cmd.load_out   = slot_free;
					cmd.out_status = mse_pkg::ST_INVALID;
				end else if (!stat.counts_eq) begin
					cmd.load_out   = slot_free;
					cmd.out_status = mse_pkg::ST_OK;
				end else if (stat.empty) begin
					cmd.load_out   = slot_free;
					cmd.out_status = mse_pkg::ST_OK;
					cmd.out_eq     = 1'b1;
				end else begin
					cmd.idx_clr = 1'b1;
					state_d     = mse_pkg::S_CMP_RD;
				end
				if (cmd.load_out) begin
					state_d = mse_pkg::S_IDLE;
				end
			end
			mse_pkg::S_CMP_RD: begin
				cmd.rd_cmp = 1'b1;
				state_d    = mse_pkg::S_CMP_CHK;
			end
			mse_pkg::S_CMP_CHK: begin
				if (!stat.words_eq || stat.last) begin
					cmd.load_out   = slot_free;
					cmd.out_status = mse_pkg::ST_OK;
					cmd.out_eq     = stat.words_eq;
					if (slot_free) begin
						state_d = mse_pkg::S_IDLE;
					end
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = mse_pkg::S_CMP_RD;
				end
			end
			default: begin
				state_d = mse_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// File: rtl/mse_datapath.sv
module mse_datapath #(
	parameter int MAX_STACKS = 8,
	parameter int MAX_DEPTH  = 128
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [mse_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [mse_pkg::CFG_DATA_W-1:0]       cfg_wdata,
	input  mse_pkg::mode_t                       in_mode,
	input  logic [mse_pkg::STACK_W-1:0]          in_stack_a,
	input  logic [mse_pkg::STACK_W-1:0]          in_stack_b,
	input  logic signed [mse_pkg::WORD_W-1:0]    in_push_value,
	input  mse_pkg::cmd_t                        cmd,
	output mse_pkg::stat_t                       stat,
	output logic [1:0]                           out_status,
	output logic signed [mse_pkg::WORD_W-1:0]    out_top_value,
	output logic                                 out_stacks_equal
);

	localparam int WORDS = MAX_STACKS * MAX_DEPTH;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

	logic [mse_pkg::NSTK_W-1:0]   stacks_q;
	logic [mse_pkg::DEPTH_W-1:0]  depth_q;
	logic [mse_pkg::DEPTH_W-1:0]  depth_eff;
	logic [mse_pkg::FILL_W-1:0]   fill_q [mse_pkg::STACK_SLOTS];

	mse_pkg::mode_t               mode_q;
	logic [mse_pkg::STACK_W-1:0]  sa_q, sb_q;
	logic [mse_pkg::WORD_W-1:0]   word_q;
	logic [mse_pkg::FILL_W-1:0]   fa_q, fb_q, idx_q;
	logic [mse_pkg::BASE_W-1:0]   base_a_q, base_b_q;
	logic [mse_pkg::WORD_W-1:0]   rd_a_q, rd_b_q;
	logic [mse_pkg::WORD_W-1:0]   store_q [WORDS];

	logic [mse_pkg::STACK_W-1:0]  fill_idx;
	logic [mse_pkg::FILL_W-1:0]   fill_rd;
	logic [mse_pkg::BASE_W-1:0]   base_new;
	logic [AW-1:0]                wr_addr, rd_addr_a, rd_addr_b;
	logic                         sa_ok, sb_ok;

	logic [1:0]                   status_q;
	logic [mse_pkg::WORD_W-1:0]   top_q;
	logic                         eq_q;

	function automatic logic [AW-1:0] addr_of(input logic [mse_pkg::BASE_W-1:0] base,
		input logic [mse_pkg::FILL_W-1:0] off);
		logic [mse_pkg::SUM_W-1:0] sum;
		sum = mse_pkg::SUM_W'(base) + mse_pkg::SUM_W'(off);
		return AW'(sum);
	endfunction

	assign depth_eff = (32'(depth_q) > MAX_DEPTH) ? mse_pkg::DEPTH_W'(MAX_DEPTH) : depth_q;

	// Stack A's fill is read straight off the input as the item is taken.
	assign fill_idx = cmd.fill_sel_b ? sb_q : in_stack_a;
	assign fill_rd  = fill_q[fill_idx];
	assign base_new = mse_pkg::BASE_W'(fill_idx) * mse_pkg::BASE_W'(depth_eff);

	assign wr_addr   = addr_of(base_a_q, fa_q);
	assign rd_addr_a = cmd.rd_peek ? addr_of(base_a_q, fa_q - 1'b1) : addr_of(base_a_q, idx_q);
	assign rd_addr_b = addr_of(base_b_q, idx_q);

	assign sa_ok = (32'(sa_q) < 32'(stacks_q)) && (32'(sa_q) < MAX_STACKS);
	assign sb_ok = (32'(sb_q) < 32'(stacks_q)) && (32'(sb_q) < MAX_STACKS);

	assign stat.mode      = mode_q;
	assign stat.invalid   = !sa_ok || ((mode_q == mse_pkg::MODE_CMP) && !sb_ok);
	assign stat.full      = fa_q >= depth_eff;
	assign stat.empty     = fa_q == '0;
	assign stat.counts_eq = fa_q == fb_q;
	assign stat.last      = idx_q == (fa_q - 1'b1);
	assign stat.words_eq  = rd_a_q == rd_b_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stacks_q <= mse_pkg::STACKS_RESET;
			depth_q  <= mse_pkg::DEPTH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				mse_pkg::CFG_STACKS: stacks_q <= cfg_wdata[mse_pkg::NSTK_W-1:0];
				mse_pkg::CFG_DEPTH:  depth_q  <= cfg_wdata[mse_pkg::DEPTH_W-1:0];
				default: ;
			endcase
		end
	end

	// Any register write empties every stack.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < mse_pkg::STACK_SLOTS; i++) begin
				fill_q[i] <= '0;
			end
		end else if (cfg_we) begin
			for (int i = 0; i < mse_pkg::STACK_SLOTS; i++) begin
				fill_q[i] <= '0;
			end
		end else if (cmd.fill_inc) begin
			fill_q[sa_q] <= fa_q + 1'b1;
		end else if (cmd.fill_dec) begin
			fill_q[sa_q] <= fa_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			mode_q   <= in_mode;
			sa_q     <= in_stack_a;
			sb_q     <= in_stack_b;
			word_q   <= in_push_value;
			fa_q     <= fill_rd;
			base_a_q <= base_new;
		end
		if (cmd.load_fb) begin
			fb_q     <= fill_rd;
			base_b_q <= base_new;
		end
		if (cmd.idx_clr) begin
			idx_q <= '0;
		end else if (cmd.idx_inc) begin
			idx_q <= idx_q + 1'b1;
		end
		if (cmd.load_out) begin
			status_q <= cmd.out_status;
			top_q    <= cmd.out_top ? rd_a_q : '0;
			eq_q     <= cmd.out_eq;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.store_wr) begin
			store_q[wr_addr] <= word_q;
		end
		if (cmd.rd_peek || cmd.rd_cmp) begin
			rd_a_q <= store_q[rd_addr_a];
		end
		if (cmd.rd_cmp) begin
			rd_b_q <= store_q[rd_addr_b];
		end
	end

	assign out_status       = status_q;
	assign out_top_value    = top_q;
	assign out_stacks_equal = eq_q;

endmodule

// File: rtl/mse_checker.sv
`include "multi_stack_engine_unit_macros.svh"

module mse_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_ready,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic [1:0]                    status,
	input logic [mse_pkg::WORD_W-1:0]    top_value,
	input logic                          stacks_equal
);

	logic [1:0] pend_q;
	logic       in_acc, out_acc;

	assign in_acc  = in_valid && in_ready;
	assign out_acc = out_valid && out_ready;

	// Track items taken whose results are not yet delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= '0;
		end else begin
			pend_q <= pend_q + {1'b0, in_acc} - {1'b0, out_acc};
		end
	end

	`MSE_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(status) && $stable(top_value) && $stable(stacks_equal), "result changed while stalled")
	`MSE_ASSERT_IMP(a_no_phantom, out_valid, pend_q != 2'd0, "result without a pending item")
	`MSE_ASSERT_IMP(a_err_zero, out_valid && status != mse_pkg::ST_OK, top_value == '0 && !stacks_equal, "error result carries data")
	`MSE_ASSERT_IMP(a_one_field, out_valid && stacks_equal, top_value == '0, "compare result carries a word")

endmodule

bind multi_stack_engine_unit mse_checker u_mse_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (op_ch.valid),
	.in_ready     (op_ch.ready),
	.out_valid    (res_ch.valid),
	.out_ready    (res_ch.ready),
	.status       (res_ch.status),
	.top_value    (res_ch.top_value),
	.stacks_equal (res_ch.stacks_equal)
);

// File: dv/multi_stack_engine_unit_tb.sv
module multi_stack_engine_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int MODEL_STACKS = 8;
	localparam int MODEL_DEPTH  = 128;
	localparam int QUIET_LIMIT  = 5000;
	localparam int PRINT_LIMIT  = 100;

	typedef struct packed {
		mse_pkg::mode_t                     mode;
		logic [mse_pkg::STACK_W-1:0]        stack_a;
		logic [mse_pkg::STACK_W-1:0]        stack_b;
		logic signed [mse_pkg::WORD_W-1:0]  push_value;
	} op_item_t;

	typedef struct packed {
		mse_pkg::status_t                   status;
		logic signed [mse_pkg::WORD_W-1:0]  top_value;
		logic                               stacks_equal;
	} outcome_t;

	logic                            clk;
	logic                            arst_n;
	logic                            cfg_we;
	logic [mse_pkg::CFG_IDX_W-1:0]   cfg_index;
	logic [mse_pkg::CFG_DATA_W-1:0]  cfg_wdata;

	mse_in_if  op_bus ();
	mse_out_if res_bus ();

	multi_stack_engine_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_ch     (op_bus),
		.res_ch    (res_bus),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow copy of the engine: register values, fill counts and word store.
	logic [mse_pkg::NSTK_W-1:0]         cfg_nstk;
	logic [mse_pkg::DEPTH_W-1:0]        cfg_depth;
	int unsigned                        stack_fill [0:MODEL_STACKS-1];
	logic signed [mse_pkg::WORD_W-1:0]  stack_words [0:MODEL_STACKS*MODEL_DEPTH-1];

	op_item_t  op_backlog [$];   // items still to be offered to the engine
	op_item_t  op_live;          // item currently on the input channel
	outcome_t  result_due [$];   // outcomes of accepted items, oldest first
	outcome_t  due_now;

	// Drop all idling while set.
	logic      steady;
	int        fail_count = 0;
	int        quiet_cycles = 0;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		if (fail_count < PRINT_LIMIT)
			$display("ERROR %0t: %s", $time, what);
		fail_count++;
	endtask

	function automatic int unsigned nstk_live();
		return (32'(cfg_nstk) > MODEL_STACKS) ? MODEL_STACKS : 32'(cfg_nstk);
	endfunction

	function automatic int unsigned depth_live();
		return (32'(cfg_depth) > MODEL_DEPTH) ? MODEL_DEPTH : 32'(cfg_depth);
	endfunction

	function automatic void clear_fills();
		foreach (stack_fill[s])
			stack_fill[s] = 0;
	endfunction

	// Apply one operation to the shadow state and return the outcome it must give.
	function automatic outcome_t stack_op_outcome(op_item_t it);
		outcome_t     r;
		int unsigned  ns, d, a, b, i;
		ns = nstk_live();
		d  = depth_live();
		a  = 32'(it.stack_a);
		b  = 32'(it.stack_b);
		r.status       = mse_pkg::ST_OK;
		r.top_value    = '0;
		r.stacks_equal = 1'b0;
		if (a >= ns || (it.mode == mse_pkg::MODE_CMP && b >= ns)) begin
			r.status = mse_pkg::ST_INVALID;
		end else begin
			case (it.mode)
				mse_pkg::MODE_PUSH: begin
					if (stack_fill[a] >= d) begin
						r.status = mse_pkg::ST_FULL;
					end else begin
						stack_words[a*d + stack_fill[a]] = it.push_value;
						stack_fill[a]++;
					end
				end
				mse_pkg::MODE_POP: begin
					if (stack_fill[a] == 0)
						r.status = mse_pkg::ST_EMPTY;
					else
						stack_fill[a]--;
				end
				mse_pkg::MODE_PEEK: begin
					if (stack_fill[a] == 0)
						r.status = mse_pkg::ST_EMPTY;
					else
						r.top_value = stack_words[a*d + stack_fill[a] - 1];
				end
				default: begin
					r.stacks_equal = (stack_fill[a] == stack_fill[b]);
					if (r.stacks_equal) begin
						for (i = 0; i < stack_fill[a]; i++)
							if (stack_words[a*d + i] != stack_words[b*d + i])
								r.stacks_equal = 1'b0;
					end
				end
			endcase
		end
		return r;
	endfunction

	function automatic void queue_op(mse_pkg::mode_t m, int unsigned a, int unsigned b,
			logic signed [mse_pkg::WORD_W-1:0] w);
		op_item_t it;
		it.mode       = m;
		it.stack_a    = mse_pkg::STACK_W'(a);
		it.stack_b    = mse_pkg::STACK_W'(b);
		it.push_value = w;
		op_backlog.push_back(it);
	endfunction

	// Mostly a live stack, now and then any number the field can hold.
	function automatic int unsigned any_stack();
		if (nstk_live() == 0 || $urandom_range(0, 9) == 0)
			return $urandom_range(0, 7);
		return $urandom_range(0, nstk_live() - 1);
	endfunction

	// Favor a small pool so that compares find equal stacks now and then.
	function automatic logic signed [mse_pkg::WORD_W-1:0] any_word();
		case ($urandom_range(0, 9))
			0: return 32'sh0;
			1: return -32'sd1;
			2: return 32'sh8000_0000;
			3: return 32'sh7fff_ffff;
			4, 5: return $urandom_range(0, 3);
			default: return $urandom;
		endcase
	endfunction

	function automatic void add_random(int unsigned n);
		int unsigned                        cnt, kind, d, a, b, k, i, cap;
		logic signed [mse_pkg::WORD_W-1:0]  w;
		cnt = 0;
		d   = depth_live();
		while (cnt < n) begin
			kind = $urandom_range(0, 99);
			a    = any_stack();
			b    = any_stack();
			if (kind < 30) begin
				queue_op(mse_pkg::mode_t'($urandom_range(0, 3)), a, b, any_word());
				cnt++;
			end else if (kind < 55) begin
				// Empty both stacks where cheap, mirror a run of words, then compare.
				if (d <= 8) begin
					for (i = 0; i < d; i++) begin
						queue_op(mse_pkg::MODE_POP, a, $urandom_range(0, 7), $urandom);
						queue_op(mse_pkg::MODE_POP, b, $urandom_range(0, 7), $urandom);
					end
					cnt += 2 * d;
				end
				k = $urandom_range(1, (d < 6) ? d + 1 : 6);
				for (i = 0; i < k; i++) begin
					w = any_word();
					queue_op(mse_pkg::MODE_PUSH, a, $urandom_range(0, 7), w);
					if (i == k - 1 && $urandom_range(0, 3) == 0)
						w = w ^ (32'sh1 << $urandom_range(0, 31));
					queue_op(mse_pkg::MODE_PUSH, b, $urandom_range(0, 7), w);
				end
				cnt += 2 * k;
				if ($urandom_range(0, 1) == 0)
					queue_op(mse_pkg::MODE_CMP, a, b, $urandom);
				else
					queue_op(mse_pkg::MODE_CMP, b, a, $urandom);
				cnt++;
			end else if (kind < 70) begin
				// Push burst, long enough at small depths to run into full.
				cap = (d + 2 < 10) ? d + 2 : 10;
				k = $urandom_range(1, cap);
				for (i = 0; i < k; i++)
					queue_op(mse_pkg::MODE_PUSH, a, $urandom_range(0, 7), any_word());
				cnt += k;
			end else if (kind < 85) begin
				// Walk down a stack, peeking at each level, past empty.
				cap = (d + 2 < 10) ? d + 2 : 10;
				k = $urandom_range(1, cap);
				for (i = 0; i < k; i++) begin
					queue_op(mse_pkg::MODE_PEEK, a, $urandom_range(0, 7), $urandom);
					queue_op(mse_pkg::MODE_POP, a, $urandom_range(0, 7), $urandom);
				end
				cnt += 2 * k;
			end else begin
				queue_op(mse_pkg::MODE_CMP, a, ($urandom_range(0, 2) == 0) ? a : b, $urandom);
				cnt++;
			end
		end
	endfunction

	// Write one register while the engine is idle; every write empties all stacks.
	task automatic cfg_write(input logic [mse_pkg::CFG_IDX_W-1:0] idx,
			input logic [mse_pkg::CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == mse_pkg::CFG_STACKS)
			cfg_nstk = data[mse_pkg::NSTK_W-1:0];
		else
			cfg_depth = data[mse_pkg::DEPTH_W-1:0];
		clear_fills();
	endtask

	// Hold until every queued item has gone in and every outcome has come back.
	task automatic wait_drained();
		do
			@(posedge clk);
		while (op_backlog.size() != 0 || op_bus.valid || result_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_config(input int unsigned stk, input int unsigned dep);
		cfg_write(mse_pkg::CFG_STACKS, {4'($urandom_range(0, 15)), 4'(stk)});
		cfg_write(mse_pkg::CFG_DEPTH, 8'(dep));
	endtask

	// Driver: offer the next backlog item, keep it steady until it is taken.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_bus.valid      <= 1'b0;
			op_bus.mode       <= mse_pkg::MODE_PUSH;
			op_bus.stack_a    <= '0;
			op_bus.stack_b    <= '0;
			op_bus.push_value <= '0;
		end else begin
			if (op_bus.valid && op_bus.ready)
				result_due.push_back(stack_op_outcome(op_live));
			if (!op_bus.valid || op_bus.ready) begin
				if (op_backlog.size() != 0 && (steady || $urandom_range(0, 99) >= 24)) begin
					op_live = op_backlog.pop_front();
					op_bus.valid      <= 1'b1;
					op_bus.mode       <= op_live.mode;
					op_bus.stack_a    <= op_live.stack_a;
					op_bus.stack_b    <= op_live.stack_b;
					op_bus.push_value <= op_live.push_value;
				end else begin
					op_bus.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor: stall at random, check each taken outcome against the oldest one due.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_bus.ready <= 1'b0;
		end else begin
			if (res_bus.valid && res_bus.ready) begin
				if (result_due.size() == 0) begin
					report_mismatch($sformatf("unexpected result status=%0d top=%0d eq=%0d",
						res_bus.status, res_bus.top_value, res_bus.stacks_equal));
				end else begin
					due_now = result_due.pop_front();
					if (res_bus.status !== due_now.status)
						report_mismatch($sformatf("status %0d, expected %s",
							res_bus.status, due_now.status.name()));
					if (res_bus.top_value !== due_now.top_value)
						report_mismatch($sformatf("top_value %0d, expected %0d",
							res_bus.top_value, due_now.top_value));
					if (res_bus.stacks_equal !== due_now.stacks_equal)
						report_mismatch($sformatf("stacks_equal %0b, expected %0b",
							res_bus.stacks_equal, due_now.stacks_equal));
				end
			end
			res_bus.ready <= steady || ($urandom_range(0, 99) >= 24);
		end
	end

	// Watchdog: end the run when nothing moves for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((op_bus.valid && op_bus.ready) || (res_bus.valid && res_bus.ready) || cfg_we)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
				$display("simulation failed");
				$finish;
			end
		end
	end

	initial begin
		int unsigned i;
		logic signed [mse_pkg::WORD_W-1:0] w;
		cfg_we       = 1'b0;
		cfg_index    = mse_pkg::CFG_STACKS;
		cfg_wdata    = '0;
		steady       = 1'b0;
		cfg_nstk     = mse_pkg::STACKS_RESET;
		cfg_depth    = mse_pkg::DEPTH_RESET;
		clear_fills();
		arst_n = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed, reset settings: empty access, extreme words, compares on equal and differing counts.
		queue_op(mse_pkg::MODE_PEEK, 0, 0, 0);
		queue_op(mse_pkg::MODE_POP, 0, 0, 0);
		queue_op(mse_pkg::MODE_PUSH, 0, 7, 32'sh8000_0000);
		queue_op(mse_pkg::MODE_PUSH, 0, 0, 32'sh7fff_ffff);
		queue_op(mse_pkg::MODE_PEEK, 0, 0, 0);
		queue_op(mse_pkg::MODE_PUSH, 1, 0, 32'sh8000_0000);
		queue_op(mse_pkg::MODE_PUSH, 1, 0, 32'sh7fff_ffff);
		queue_op(mse_pkg::MODE_CMP, 0, 1, 0);
		queue_op(mse_pkg::MODE_CMP, 3, 3, 0);
		queue_op(mse_pkg::MODE_CMP, 0, 2, 0);
		queue_op(mse_pkg::MODE_POP, 0, 0, 0);
		queue_op(mse_pkg::MODE_PEEK, 0, 0, 0);
		queue_op(mse_pkg::MODE_CMP, 0, 1, 0);
		queue_op(mse_pkg::MODE_PUSH, 7, 7, -32'sd1);
		queue_op(mse_pkg::MODE_PEEK, 7, 0, 0);
		queue_op(mse_pkg::MODE_CMP, 7, 7, 0);
		wait_drained();

		// Three stacks of two: full push, invalid numbers on every operation.
		set_config(3, 2);
		queue_op(mse_pkg::MODE_PUSH, 0, 0, 32'sd5);
		queue_op(mse_pkg::MODE_PUSH, 0, 0, 32'sd6);
		queue_op(mse_pkg::MODE_PUSH, 0, 0, 32'sd7);
		queue_op(mse_pkg::MODE_PUSH, 3, 0, 32'sd8);
		queue_op(mse_pkg::MODE_POP, 4, 0, 0);
		queue_op(mse_pkg::MODE_PEEK, 6, 0, 0);
		queue_op(mse_pkg::MODE_CMP, 0, 5, 0);
		queue_op(mse_pkg::MODE_CMP, 5, 0, 0);
		queue_op(mse_pkg::MODE_CMP, 1, 2, 0);
		wait_drained();

		// Zero depth: full and empty at once. Then no stacks at all.
		set_config(15, 0);
		queue_op(mse_pkg::MODE_PUSH, 0, 0, 32'sd1);
		queue_op(mse_pkg::MODE_POP, 0, 0, 0);
		queue_op(mse_pkg::MODE_PEEK, 0, 0, 0);
		queue_op(mse_pkg::MODE_CMP, 0, 7, 0);
		wait_drained();
		set_config(0, 3);
		queue_op(mse_pkg::MODE_PUSH, 0, 0, 32'sd1);
		queue_op(mse_pkg::MODE_CMP, 0, 0, 0);
		wait_drained();

		// Oversized registers clamp to 8 x 128: fill two stacks to the top and compare.
		set_config(15, 255);
		for (i = 0; i < MODEL_DEPTH; i++) begin
			w = any_word();
			queue_op(mse_pkg::MODE_PUSH, 2, $urandom_range(0, 7), w);
			queue_op(mse_pkg::MODE_PUSH, 5, $urandom_range(0, 7), w);
		end
		queue_op(mse_pkg::MODE_PUSH, 2, 0, 32'sd9);
		queue_op(mse_pkg::MODE_CMP, 2, 5, 0);
		queue_op(mse_pkg::MODE_CMP, 5, 2, 0);
		queue_op(mse_pkg::MODE_PEEK, 5, 0, 0);
		add_random(40);
		wait_drained();

		// No idling at all here, with a full drain halfway through.
		set_config(4, 4);
		steady = 1'b1;
		add_random(150);
		wait_drained();
		add_random(150);
		wait_drained();
		steady = 1'b0;

		set_config(8, 1);
		add_random(180);
		wait_drained();

		set_config(1, 7);
		add_random(180);
		wait_drained();

		set_config(0, 3);
		add_random(40);
		wait_drained();

		set_config(5, 0);
		add_random(60);
		wait_drained();

		repeat (3) begin
			set_config($urandom_range(0, 15),
				($urandom_range(0, 4) == 0) ? $urandom_range(129, 255) : $urandom_range(0, 12));
			add_random(80);
			wait_drained();
		end

		// Give a stray result time to show up after the last expected one.
		repeat (300) @(posedge clk);
		if (fail_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule

// File: files.f
+incdir+rtl
rtl/mse_pkg.sv
rtl/mse_in_if.sv
rtl/mse_out_if.sv
rtl/mse_ctrl.sv
rtl/mse_datapath.sv
rtl/multi_stack_engine_unit.sv
rtl/mse_checker.sv
dv/multi_stack_engine_unit_tb.sv
